// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the recurrence term block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off during reset
`define LRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds while reset is applied
`define LRT_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/lrt_pkg.sv -----
// Package: widths, codes and controller/datapath interface types
package lrt_pkg;

  localparam int unsigned ValW = 31;
  localparam int unsigned IdxW = 63;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ProdW = 2 * ValW;
  localparam int unsigned NumW = ProdW + 1;
  localparam int unsigned CntW = $clog2(NumW);

  localparam logic [CfgIdxW-1:0] CFG_MODULUS = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_COEF_00 = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_COEF_01 = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_COEF_10 = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_COEF_11 = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_INIT_0 = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_INIT_1 = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ROUND,
    ST_ISSUE,
    ST_WAIT
  } state_e;

  typedef enum logic [1:0] {
    OP_RB,
    OP_BB,
    OP_FIN
  } op_e;

  typedef enum logic [1:0] {
    OSEL_F0,
    OSEL_F1,
    OSEL_ZERO,
    OSEL_MAC
  } out_sel_e;

  typedef struct packed {
    logic     init;
    logic     mac_go;
    logic     first;
    op_e      op;
    logic [1:0] elem;
    logic     k;
    logic     commit_res;
    logic     commit_base;
    logic     shift_e;
    logic     out_en;
    out_sel_e out_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic n_is0;
    logic n_is1;
    logic m_zero;
    logic e_zero;
    logic e_lsb;
    logic mac_done;
  } dp_stat_t;

endpackage

// ----- rtl/lrt_mulmod.sv -----
// Modular multiply-accumulate: (addend + a*b) mod m, one remainder bit per cycle
`include "assert_macros.svh"
module lrt_mulmod import lrt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            go_i,
  input  logic [ValW-1:0] a_i,
  input  logic [ValW-1:0] b_i,
  input  logic [ValW-1:0] addend_i,
  input  logic [ValW-1:0] mod_i,
  output logic            done_o,
  output logic [ValW-1:0] rem_o
);

  logic            mul_q, run_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [ProdW-1:0] prod_q;
  logic [ValW-1:0] addend_q;
  logic [NumW-1:0] num_q;
  logic [ValW-1:0] rem_q, rem_d;
  logic [ValW:0]   rem_sh;

  always_comb begin
    rem_sh = {rem_q, num_q[NumW-1]};
    if (rem_sh >= {1'b0, mod_i}) begin
      rem_d = ValW'(rem_sh - {1'b0, mod_i});
    end else begin
      rem_d = rem_sh[ValW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      mul_q  <= go_i;
      if (mul_q) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(NumW - 1);
      end else if (run_q) begin
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      prod_q   <= a_i * b_i;
      addend_q <= addend_i;
    end
    if (mul_q) begin
      num_q <= {1'b0, prod_q} + NumW'(addend_q);
      rem_q <= '0;
    end else if (run_q) begin
      num_q <= {num_q[NumW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  `LRT_ASSERT(a_go_idle, go_i |-> !(mul_q || run_q), "mulmod started while busy")
  `LRT_ASSERT(a_rem_below, (done_q && mod_i != '0) |-> (rem_q < mod_i), "remainder not reduced")

endmodule

// ----- rtl/lrt_datapath.sv -----
// Datapath: configuration, matrices, exponent and result register
module lrt_datapath import lrt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ValW-1:0]    cfg_data_i,
  input  logic [IdxW-1:0]    term_index_i,
  input  ctrl_cmd_t          cmd_i,
  output dp_stat_t           stat_o,
  output logic               done_o,
  output logic [ValW-1:0]    term_value_o
);

  logic [ValW-1:0] mod_q, c_q [4], f0_q, f1_q;
  logic [ValW-1:0] res_q [4], base_q [4], t_q [4];
  logic [IdxW-1:0] n_q, e_q;
  logic            out_en_q;
  logic [ValW-1:0] out_q;
  logic [ValW-1:0] op_a, op_b, addend, mm_rem;
  logic            mm_done;
  logic [1:0]      ia, ib;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q  <= ValW'(1000000007);
      c_q[0] <= ValW'(1);
      c_q[1] <= ValW'(1);
      c_q[2] <= ValW'(1);
      c_q[3] <= ValW'(0);
      f0_q   <= ValW'(1);
      f1_q   <= ValW'(2);
      out_en_q <= 1'b0;
    end else begin
      out_en_q <= cmd_i.out_en;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MODULUS: mod_q  <= cfg_data_i;
          CFG_COEF_00: c_q[0] <= cfg_data_i;
          CFG_COEF_01: c_q[1] <= cfg_data_i;
          CFG_COEF_10: c_q[2] <= cfg_data_i;
          CFG_COEF_11: c_q[3] <= cfg_data_i;
          CFG_INIT_0:  f0_q   <= cfg_data_i;
          CFG_INIT_1:  f1_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    ia = {cmd_i.elem[1], cmd_i.k};
    ib = {cmd_i.k, cmd_i.elem[0]};
    case (cmd_i.op)
      OP_RB: begin
        op_a = res_q[ia];
        op_b = base_q[ib];
      end
      OP_BB: begin
        op_a = base_q[ia];
        op_b = base_q[ib];
      end
      default: begin
        op_a = cmd_i.k ? f0_q : f1_q;
        op_b = res_q[{1'b0, cmd_i.k}];
      end
    endcase
    addend = cmd_i.first ? '0 : mm_rem;
  end

  lrt_mulmod u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (cmd_i.mac_go),
    .a_i      (op_a),
    .b_i      (op_b),
    .addend_i (addend),
    .mod_i    (mod_q),
    .done_o   (mm_done),
    .rem_o    (mm_rem)
  );

  // last element arrives on the commit edge, so take it from the unit
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      n_q <= term_index_i;
      e_q <= term_index_i - IdxW'(1);
      res_q[0] <= ValW'(1);
      res_q[1] <= '0;
      res_q[2] <= '0;
      res_q[3] <= ValW'(1);
      base_q <= c_q;
    end else begin
      if (cmd_i.commit_res) res_q <= '{t_q[0], t_q[1], t_q[2], mm_rem};
      if (cmd_i.commit_base) base_q <= '{t_q[0], t_q[1], t_q[2], mm_rem};
      if (cmd_i.shift_e) e_q <= e_q >> 1;
    end
    if (mm_done) t_q[cmd_i.elem] <= mm_rem;
    if (cmd_i.out_en) begin
      case (cmd_i.out_sel)
        OSEL_F0:   out_q <= f0_q;
        OSEL_F1:   out_q <= f1_q;
        OSEL_ZERO: out_q <= '0;
        default:   out_q <= mm_rem;
      endcase
    end
  end

  assign stat_o.n_is0    = (n_q == '0);
  assign stat_o.n_is1    = (n_q == IdxW'(1));
  assign stat_o.m_zero   = (mod_q == '0);
  assign stat_o.e_zero   = (e_q == '0);
  assign stat_o.e_lsb    = e_q[0];
  assign stat_o.mac_done = mm_done;
  assign done_o          = out_en_q;
  assign term_value_o    = out_q;

endmodule

// ----- rtl/lrt_ctrl.sv -----
// Controller: sequences square-and-multiply rounds over the shared mulmod unit
`include "assert_macros.svh"
module lrt_ctrl import lrt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o,
  output logic      busy_o
);

  state_e     state_q, state_d;
  op_e        op_q, op_d;
  logic [1:0] elem_q, elem_d;
  logic       k_q, k_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_RB;
      elem_q  <= '0;
      k_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      elem_q  <= elem_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    elem_d  = elem_q;
    k_d     = k_q;
    cmd_o   = '0;
    cmd_o.op    = op_q;
    cmd_o.elem  = elem_q;
    cmd_o.k     = k_q;
    cmd_o.first = !k_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.init = 1'b1;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (stat_i.n_is0 || stat_i.n_is1 || stat_i.m_zero) begin
          cmd_o.out_en  = 1'b1;
          cmd_o.out_sel = stat_i.n_is0 ? OSEL_F0 : (stat_i.n_is1 ? OSEL_F1 : OSEL_ZERO);
          state_d = ST_IDLE;
        end else begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        elem_d = '0;
        k_d = 1'b0;
        if (stat_i.e_zero) op_d = OP_FIN;
        else if (stat_i.e_lsb) op_d = OP_RB;
        else op_d = OP_BB;
        state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        cmd_o.mac_go = 1'b1;
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (stat_i.mac_done) begin
          state_d = ST_ISSUE;
          if (!k_q) begin
            k_d = 1'b1;
          end else if (op_q == OP_FIN) begin
            cmd_o.out_en  = 1'b1;
            cmd_o.out_sel = OSEL_MAC;
            state_d = ST_IDLE;
          end else if (elem_q == 2'd3) begin
            k_d = 1'b0;
            elem_d = '0;
            if (op_q == OP_RB) begin
              cmd_o.commit_res = 1'b1;
              op_d = OP_BB;
            end else begin
              cmd_o.commit_base = 1'b1;
              cmd_o.shift_e = 1'b1;
              state_d = ST_ROUND;
            end
          end else begin
            k_d = 1'b0;
            elem_d = elem_q + 2'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  `LRT_ASSERT(a_one_issue, cmd_o.mac_go |=> !cmd_o.mac_go, "mulmod issued twice in a row")
  `LRT_ASSERT_ALL(a_idle_no_go, (state_q == ST_IDLE) |-> !cmd_o.mac_go, "mulmod issued in idle")

endmodule

// ----- rtl/linear_recurrence_term_mod.sv -----
// Top level: n-th term of a 2x2 modular linear recurrence by matrix power
//
//  channel   signals                                  transfer when
//  input     start, busy, term_index_i                start && !busy
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i,   cfg_valid_i && cfg_ready_o
//            cfg_data_i
//  result    term_valid_o, term_value_o               term_valid_o (one cycle)
//
// Index 0, 1 or zero modulus: the result is registered straight from the dispatch state.
// Otherwise each multiply-accumulate runs on the single bit-serial mulmod unit;
// a round needs 8 of them (square) or 16 (multiply and square), plus 2 to finish;
// there is one round per bit of n-1, with the multiply only for its set bits.
// Reset is asynchronous, active low. The result cannot be stalled.
module linear_recurrence_term_mod import lrt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [IdxW-1:0]    term_index_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ValW-1:0]    cfg_data_i,
  output logic               term_valid_o,
  output logic [ValW-1:0]    term_value_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready_o = 1'b1;

  lrt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  lrt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .term_index_i (term_index_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .done_o       (term_valid_o),
    .term_value_o (term_value_o)
  );

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the modular linear recurrence term block
`timescale 1ns / 100ps

module testbench import lrt_pkg::*; ();

  localparam logic [CfgIdxW-1:0] CFG_SPARE = 3'd7;
  localparam int unsigned StallLimit = 400000;
  localparam logic [ValW-1:0] ValMax = {ValW{1'b1}};

  typedef longint unsigned mat_t [4];

  class term_scoreboard;
    logic [ValW-1:0] regs [7];
    logic [ValW-1:0] expected_terms [$];
    int unsigned errors;
    int unsigned checked;

    function new();
      regs[CFG_MODULUS] = 31'd1000000007;
      regs[CFG_COEF_00] = 31'd1;
      regs[CFG_COEF_01] = 31'd1;
      regs[CFG_COEF_10] = 31'd1;
      regs[CFG_COEF_11] = 31'd0;
      regs[CFG_INIT_0]  = 31'd1;
      regs[CFG_INIT_1]  = 31'd2;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [ValW-1:0] val);
      if (idx <= CFG_INIT_1) regs[idx] = val;
    endfunction

    function mat_t mat_mul(mat_t a, mat_t b, longint unsigned m);
      mat_t t;
      longint unsigned acc;
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          acc = 0;
          for (int k = 0; k < 2; k++) acc = (acc + a[i*2+k] * b[k*2+j]) % m;
          t[i*2+j] = acc;
        end
      end
      return t;
    endfunction

    function logic [ValW-1:0] recurrence_term(logic [IdxW-1:0] n);
      longint unsigned m, e, acc, f0, f1;
      mat_t r, b;
      m = regs[CFG_MODULUS];
      f0 = regs[CFG_INIT_0];
      f1 = regs[CFG_INIT_1];
      if (n == 0) return regs[CFG_INIT_0];
      if (n == 1) return regs[CFG_INIT_1];
      if (m == 0) return '0;
      r = '{1, 0, 0, 1};
      b = '{regs[CFG_COEF_00], regs[CFG_COEF_01], regs[CFG_COEF_10], regs[CFG_COEF_11]};
      e = n - 1;
      while (e > 0) begin
        if (e[0]) r = mat_mul(r, b, m);
        b = mat_mul(b, b, m);
        e = e >> 1;
      end
      acc = (f1 * r[0]) % m;
      acc = (acc + f0 * r[1]) % m;
      return acc[ValW-1:0];
    endfunction

    function void note_index(logic [IdxW-1:0] n);
      expected_terms.insert(expected_terms.size(), recurrence_term(n));
    endfunction

    function void check_term(logic [ValW-1:0] actual);
      logic [ValW-1:0] want;
      if (expected_terms.size() == 0) begin
        $display("%0t: unexpected term %0d, expected none", $time, actual);
        errors++;
        return;
      end
      want = expected_terms.pop_front();
      checked++;
      if (actual !== want) begin
        $display("%0t: term_value mismatch, expected %0d actual %0d", $time, want, actual);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [IdxW-1:0]    term_index_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [ValW-1:0]    cfg_data_i;
  logic               term_valid_o;
  logic [ValW-1:0]    term_value_o;

  term_scoreboard sb;
  int unsigned stall_cycles;
  int unsigned items_sent;
  int unsigned cfg_writes;
  bit no_idle;

  linear_recurrence_term_mod u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .term_index_i (term_index_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .term_valid_o (term_valid_o),
    .term_value_o (term_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && term_valid_o) sb.check_term(term_value_o);
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || term_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: watchdog expired", $time);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [ValW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.expected_terms.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_index(logic [IdxW-1:0] n);
    start        <= 1'b1;
    term_index_i <= n;
    do @(posedge clk_i); while (busy);
    sb.note_index(n);
    items_sent++;
    if (!no_idle && $urandom_range(99) < 33) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  endtask

  task automatic set_all(logic [ValW-1:0] m, logic [ValW-1:0] c00, logic [ValW-1:0] c01,
                         logic [ValW-1:0] c10, logic [ValW-1:0] c11,
                         logic [ValW-1:0] f0, logic [ValW-1:0] f1);
    start <= 1'b0;
    drain();
    write_cfg(CFG_MODULUS, m);
    write_cfg(CFG_COEF_00, c00);
    write_cfg(CFG_COEF_01, c01);
    write_cfg(CFG_COEF_10, c10);
    write_cfg(CFG_COEF_11, c11);
    write_cfg(CFG_INIT_0, f0);
    write_cfg(CFG_INIT_1, f1);
  endtask

  function automatic logic [ValW-1:0] rand_val();
    case ($urandom_range(5))
      0: return '0;
      1: return ValMax;
      2: return ValMax - 1'b1;
      default: return ValW'($urandom());
    endcase
  endfunction

  function automatic logic [IdxW-1:0] rand_index();
    logic [63:0] wide;
    int unsigned pick;
    pick = $urandom_range(99);
    wide = {$urandom(), $urandom()};
    if (pick < 30) return IdxW'($urandom_range(3));
    if (pick < 97) return IdxW'($urandom_range(64, 4));
    return wide[IdxW-1:0];
  endfunction

  task automatic random_phase(int unsigned count);
    logic [ValW-1:0] m;
    m = ($urandom_range(3) == 0) ? rand_val() : ValW'($urandom_range(1000, 2));
    set_all(m, rand_val(), rand_val(), rand_val(), rand_val(), rand_val(), rand_val());
    for (int i = 0; i < count; i++) send_index(rand_index());
  endtask

  initial begin
    sb = new();
    rst_ni       = 1'b0;
    start        = 1'b0;
    term_index_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_MODULUS;
    cfg_data_i   = '0;
    stall_cycles = 0;
    items_sent   = 0;
    cfg_writes   = 0;
    no_idle      = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration, index extremes and bit patterns
    send_index('0);
    send_index(IdxW'(1));
    send_index(IdxW'(2));
    send_index(IdxW'(3));
    send_index(IdxW'(40));
    send_index({IdxW{1'b1}});
    send_index({1'b1, {(IdxW-1){1'b0}}});
    send_index({1'b1, {31{2'b01}}});
    start <= 1'b0;
    drain();

    // widest operands
    set_all(ValMax, ValMax - 1'b1, ValMax - 1'b1, ValMax - 1'b1, ValMax - 1'b1,
            ValMax - 1'b1, ValMax - 1'b1);
    send_index('0);
    send_index(IdxW'(1));
    send_index(IdxW'(17));
    send_index({{31{2'b10}}, 1'b0});
    // modulus one, coefficients left unreduced
    set_all(31'd1, 31'd5, 31'd9, ValMax, 31'd3, 31'd77, ValMax);
    send_index('0);
    send_index(IdxW'(1));
    send_index(IdxW'(9));
    // zero modulus
    set_all('0, 31'd2, 31'd3, 31'd4, 31'd5, 31'd6, 31'd7);
    send_index('0);
    send_index(IdxW'(1));
    send_index(IdxW'(2));
    send_index({IdxW{1'b1}});
    // configuration above a small modulus, plus a write to an unused index
    set_all(31'd7, 31'd100, ValMax, 31'd8, 31'd0, 31'd50, 31'd9);
    write_cfg(CFG_SPARE, 31'h1234567);
    send_index('0);
    send_index(IdxW'(1));
    send_index(IdxW'(12));
    start <= 1'b0;
    drain();

    for (int p = 0; p < 4; p++) begin
      no_idle = (p == 2);
      random_phase(66);
    end
    start <= 1'b0;
    drain();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d term requests over %0d register writes; %0d terms checked.",
             items_sent, cfg_writes, sb.checked);
    $display("Covered index 0/1, zero and unit moduli, full-width indices and operands.");
    if (sb.errors == 0 && sb.expected_terms.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0t: %0d errors, %0d terms still expected", $time, sb.errors,
               sb.expected_terms.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/lrt_pkg.sv
rtl/lrt_mulmod.sv
rtl/lrt_datapath.sv
rtl/lrt_ctrl.sv
rtl/linear_recurrence_term_mod.sv
verif/testbench.sv
